>>> hw/rtl/rca_pkg.sv
// ----------------------------------------------------------------------------
// rca_pkg: shared types and constants for the route cache
// Holds codes, field widths and the request word that links front and back.
// ----------------------------------------------------------------------------
package rca_pkg;

    localparam int ROUTE_ENTRIES_DEF = 32;
    localparam int PORT_SLOTS_DEF    = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int ADDR_W  = 32;
    localparam int MAC_W   = 48;
    localparam int IFC_W   = 8;
    localparam int PORT_W  = 4;
    localparam int HOPS_W  = 8;
    localparam int TIME_W  = 32;
    localparam int STALE_W = 16;
    localparam int SLOT_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 1'b1;

    localparam logic [STALE_W-1:0] STALE_LIMIT_RESET = 16'd60;

    typedef enum logic [1:0] {
        RS_MISSING = 2'd0,
        RS_STALE   = 2'd1,
        RS_FRESH   = 2'd2
    } t_route_state;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_APPENDED  = 2'd1,
        ACT_OVERWRITE = 2'd2,
        ACT_FULL      = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_DECIDE,
        ST_READ,
        ST_REPLY
    } t_back_state;

    // One classified word from the front part.
    typedef struct packed {
        logic              learn;
        logic [ADDR_W-1:0] key;
        logic [MAC_W-1:0]  mac;
        logic [IFC_W-1:0]  ifc;
        logic [PORT_W-1:0] port;
        logic [HOPS_W-1:0] hops;
        logic              forced;
        logic [TIME_W-1:0] now;
    } t_request;

endpackage

>>> hw/rtl/rca_front.sv
// ----------------------------------------------------------------------------
// rca_front: input stage and request queue
// Accepts words, marks learns about this node's own address as lookups and queues them.
// ----------------------------------------------------------------------------
module rca_front #(
    parameter int PORT_SLOTS = rca_pkg::PORT_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rca_pkg::ADDR_W-1:0] i_own_address,
    input  rca_pkg::t_request          i_req,
    output logic                       o_req_valid,
    input  logic                       i_req_pop,
    output rca_pkg::t_request          o_req
);

    localparam int QD  = rca_pkg::QUEUE_DEPTH;
    localparam int QPW = $clog2(QD);
    localparam int PW  = rca_pkg::PORT_W;
    localparam int PORT_VALUES = 2 ** PW;

    // Every possible port slot value mapped to its value modulo PORT_SLOTS.
    function automatic logic [PORT_VALUES*PW-1:0] port_wrap_table();
        logic [PORT_VALUES*PW-1:0] t;
        t = '0;
        for (int v = 0; v < PORT_VALUES; v++) begin
            t[v*PW +: PW] = PW'(v % PORT_SLOTS);
        end
        return t;
    endfunction

    localparam logic [PORT_VALUES*PW-1:0] PORT_WRAP = port_wrap_table();

    rca_pkg::t_request     r_q [QD];
    logic [QPW-1:0]        r_wp, r_rp;
    logic [QPW:0]          r_cnt;
    rca_pkg::t_request     w_cls;
    logic                  w_push;

    always_comb begin
        w_cls = i_req;
        // Learns about this node's own address only look up.
        if (i_req.key == i_own_address) begin
            w_cls.learn = 1'b0;
        end
        w_cls.port = PORT_WRAP[32'(i_req.port) * PW +: PW];
    end

    assign o_ready     = (r_cnt != (QPW+1)'(QD));
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (32'(r_wp) == QD-1) ? '0 : r_wp + 1'b1;
            end
            if (i_req_pop && o_req_valid) begin
                r_rp <= (32'(r_rp) == QD-1) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPW+1)'(w_push) - (QPW+1)'(i_req_pop && o_req_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
    end

endmodule

>>> hw/rtl/rca_back.sv
// ----------------------------------------------------------------------------
// rca_back: table scan and update
// Scans used entries one at a time, decides the update and writes it back.
// ----------------------------------------------------------------------------
module rca_back #(
    parameter int ROUTE_ENTRIES = rca_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rca_pkg::STALE_W-1:0] i_stale_limit,
    input  logic                        i_req_valid,
    output logic                        o_req_pop,
    input  rca_pkg::t_request           i_req,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_route_state,
    output logic [rca_pkg::SLOT_W-1:0]  o_entry_slot,
    output logic [rca_pkg::MAC_W-1:0]   o_next_mac,
    output logic [rca_pkg::IFC_W-1:0]   o_route_interface,
    output logic [rca_pkg::PORT_W-1:0]  o_route_port,
    output logic [rca_pkg::HOPS_W-1:0]  o_route_hops,
    output logic [1:0]                  o_action
);

    localparam int IW = $clog2(ROUTE_ENTRIES);
    localparam int DW = rca_pkg::MAC_W + rca_pkg::IFC_W + rca_pkg::PORT_W
                        + rca_pkg::HOPS_W;
    localparam int TIME_W_L = rca_pkg::TIME_W;

    logic [rca_pkg::ADDR_W-1:0] m_addr  [ROUTE_ENTRIES];
    logic [rca_pkg::TIME_W-1:0] m_stamp [ROUTE_ENTRIES];
    logic [DW-1:0]              m_data  [ROUTE_ENTRIES];

    rca_pkg::t_back_state r_st, n_st;
    logic [IW:0]          r_used, n_used;
    logic [IW:0]          r_idx, n_idx;
    logic [rca_pkg::ADDR_W-1:0] r_rd_addr;
    logic [rca_pkg::TIME_W-1:0] r_rd_stamp;
    logic [DW-1:0]        r_rd_data;
    logic                 r_out_v, n_out_v;
    rca_pkg::t_route_state r_state, n_state;
    rca_pkg::t_action     r_act, n_act;
    logic                 r_have, n_have;
    logic [IW-1:0]        r_slot, n_slot;
    logic                 w_we;
    logic [IW-1:0]        w_rd_idx;
    logic [TIME_W_L-1:0]  w_age;

    assign w_age = i_req.now - r_rd_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= rca_pkg::ST_IDLE;
            r_used  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_used  <= n_used;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_state <= n_state;
        r_act   <= n_act;
        r_have  <= n_have;
        r_slot  <= n_slot;
    end

    always_comb begin
        n_st      = r_st;
        n_used    = r_used;
        n_idx     = r_idx;
        n_state   = r_state;
        n_act     = r_act;
        n_have    = r_have;
        n_slot    = r_slot;
        n_out_v   = r_out_v && !i_ready;
        o_req_pop = 1'b0;
        w_we      = 1'b0;
        w_rd_idx  = r_idx[IW-1:0];
        unique case (r_st)
            rca_pkg::ST_IDLE: begin
                n_idx   = '0;
                n_state = rca_pkg::RS_MISSING;
                n_act   = rca_pkg::ACT_NONE;
                n_have  = 1'b0;
                n_slot  = '0;
                w_rd_idx = '0;
                if (i_req_valid) begin
                    n_st = rca_pkg::ST_SCAN;
                end
            end
            rca_pkg::ST_SCAN: begin
                // Memory read for r_idx is issued; data lands next cycle.
                if (r_idx >= r_used) begin
                    n_st = rca_pkg::ST_DECIDE;
                end else begin
                    n_st = rca_pkg::ST_CHECK;
                end
            end
            rca_pkg::ST_CHECK: begin
                if (r_rd_addr == i_req.key) begin
                    n_state = (w_age > TIME_W_L'(i_stale_limit)) ?
                              rca_pkg::RS_STALE : rca_pkg::RS_FRESH;
                    n_have  = 1'b1;
                    n_slot  = r_idx[IW-1:0];
                    n_st    = rca_pkg::ST_DECIDE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_st  = rca_pkg::ST_SCAN;
                    w_rd_idx = n_idx[IW-1:0];
                end
            end
            rca_pkg::ST_DECIDE: begin
                w_rd_idx = r_slot;
                if (i_req.learn) begin
                    priority if (r_state == rca_pkg::RS_MISSING) begin
                        if (32'(r_used) < ROUTE_ENTRIES) begin
                            n_slot = r_used[IW-1:0];
                            n_used = r_used + 1'b1;
                            n_have = 1'b1;
                            n_act  = rca_pkg::ACT_APPENDED;
                            w_we   = 1'b1;
                        end else begin
                            n_act = rca_pkg::ACT_FULL;
                        end
                    end else if (r_state == rca_pkg::RS_STALE || i_req.forced ||
                                 i_req.hops <= r_rd_data[rca_pkg::HOPS_W-1:0]) begin
                        n_act = rca_pkg::ACT_OVERWRITE;
                        w_we  = 1'b1;
                    end else begin
                        n_act = rca_pkg::ACT_NONE;
                    end
                end
                n_st = rca_pkg::ST_READ;
            end
            rca_pkg::ST_READ: begin
                w_rd_idx = r_slot;
                if (!r_out_v || i_ready) begin
                    n_st = rca_pkg::ST_REPLY;
                end
            end
            rca_pkg::ST_REPLY: begin
                w_rd_idx  = r_slot;
                n_out_v   = 1'b1;
                o_req_pop = 1'b1;
                n_st      = rca_pkg::ST_IDLE;
            end
            default: n_st = rca_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= m_addr[w_rd_idx];
        r_rd_stamp <= m_stamp[w_rd_idx];
        r_rd_data  <= m_data[w_rd_idx];
        if (w_we) begin
            m_addr[n_slot]  <= i_req.key;
            m_stamp[n_slot] <= i_req.now;
            m_data[n_slot]  <= {i_req.mac, i_req.ifc, i_req.port, i_req.hops};
        end
    end

    // Output register, loaded as the request retires.
    always_ff @(posedge i_clk) begin
        if (r_st == rca_pkg::ST_REPLY) begin
            o_route_state <= r_state;
            o_action      <= r_act;
            o_entry_slot  <= r_have ? rca_pkg::SLOT_W'(r_slot) : '0;
            {o_next_mac, o_route_interface, o_route_port, o_route_hops} <=
                r_have ? r_rd_data : '0;
        end
    end

    assign o_valid = r_out_v;

endmodule

>>> hw/rtl/route_cache_with_aging.sv
// ----------------------------------------------------------------------------
// route_cache_with_aging: route table with lookup, learn and aging
// Front stage queues words; back stage scans the table and updates it.
// ----------------------------------------------------------------------------
//  channel   signals                  handshake
//  input     i_valid / o_ready        accepted when both high
//  output    o_valid / i_ready        accepted when both high
//  config    i_cfg_we, idx, data      write when i_cfg_we high
//
// From the queue head to the result register a word passes idle, a scan
// and check of each used entry up to a match via the table memory read port,
// decide, read (held while an unaccepted result waits) and reply.
// Reset clears fill count, queue, state and config; there is no clearing pass.
// The queue takes a new word while the result register waits on i_ready.
module route_cache_with_aging #(
    parameter int ROUTE_ENTRIES = rca_pkg::ROUTE_ENTRIES_DEF,
    parameter int PORT_SLOTS    = rca_pkg::PORT_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rca_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rca_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [rca_pkg::ADDR_W-1:0]    i_key_address,
    input  logic [rca_pkg::MAC_W-1:0]     i_hop_mac,
    input  logic [rca_pkg::IFC_W-1:0]     i_os_interface,
    input  logic [rca_pkg::PORT_W-1:0]    i_port_slot,
    input  logic [rca_pkg::HOPS_W-1:0]    i_hops,
    input  logic                          i_forced_discovery,
    input  logic [rca_pkg::TIME_W-1:0]    i_now_seconds,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_route_state,
    output logic [rca_pkg::SLOT_W-1:0]    o_entry_slot,
    output logic [rca_pkg::MAC_W-1:0]     o_next_mac,
    output logic [rca_pkg::IFC_W-1:0]     o_route_interface,
    output logic [rca_pkg::PORT_W-1:0]    o_route_port,
    output logic [rca_pkg::HOPS_W-1:0]    o_route_hops,
    output logic [1:0]                    o_action
);

    logic [rca_pkg::ADDR_W-1:0]  r_own;
    logic [rca_pkg::STALE_W-1:0] r_stale;
    rca_pkg::t_request           w_in, w_req;
    logic                        w_req_valid, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own   <= '0;
            r_stale <= rca_pkg::STALE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rca_pkg::CFG_OWN_ADDRESS: r_own <= i_cfg_data;
                rca_pkg::CFG_STALE_LIMIT: r_stale <= i_cfg_data[rca_pkg::STALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_in = '{learn: i_mode, key: i_key_address, mac: i_hop_mac,
                    ifc: i_os_interface, port: i_port_slot, hops: i_hops,
                    forced: i_forced_discovery, now: i_now_seconds};

    rca_front #(.PORT_SLOTS(PORT_SLOTS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_own_address(r_own), .i_req(w_in),
        .o_req_valid(w_req_valid), .i_req_pop(w_pop), .o_req(w_req)
    );

    rca_back #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_stale_limit(r_stale),
        .i_req_valid(w_req_valid), .o_req_pop(w_pop), .i_req(w_req),
        .o_valid, .i_ready, .o_route_state, .o_entry_slot, .o_next_mac,
        .o_route_interface, .o_route_port, .o_route_hops, .o_action
    );

endmodule

>>> hw/rtl/rca_checker.sv
// ----------------------------------------------------------------------------
// rca_checker: port-level assertions for the route cache
// Watches handshakes and result codes on the top level's ports.
// ----------------------------------------------------------------------------
module rca_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_route_state,
    input logic [1:0] o_action,
    input logic [4:0] o_entry_slot
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result word dropped");

    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_route_state <= rca_pkg::RS_FRESH) else $error("bad route state");

    a_append_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action == rca_pkg::ACT_APPENDED || o_action == rca_pkg::ACT_FULL)
        |-> o_route_state == rca_pkg::RS_MISSING)
        else $error("append on existing route");

    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_route_state == rca_pkg::RS_MISSING &&
        o_action != rca_pkg::ACT_APPENDED |-> o_entry_slot == '0)
        else $error("slot reported on miss");

endmodule

bind route_cache_with_aging rca_checker u_rca_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_route_state, .o_action, .o_entry_slot
);
